### design/window_watchdog_timing_solver_defines.svh
// Assertion macros for the window watchdog timing solver
`ifndef WINDOW_WATCHDOG_TIMING_SOLVER_DEFINES_SVH
`define WINDOW_WATCHDOG_TIMING_SOLVER_DEFINES_SVH

`define WWTS_ASSERT_IMP(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define WWTS_ASSERT_NXT(label, clock, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wwts_pkg.sv
// Package: types and constants of the window watchdog timing solver
package wwts_pkg;

	localparam logic [31:0] DEFAULT_CLOCK_HZ = 32'd108000000;
	localparam int          NUM_DIVIDERS_DEF = 4;
	localparam int          BASE_SHIFT       = 12;
	localparam int          MS_PER_S         = 1000;
	localparam logic [6:0]  COUNT_LOW        = 7'h40;
	localparam logic [6:0]  COUNT_HIGH       = 7'h7F;

	localparam int MS_W     = 16;
	localparam int CLK_W    = 32;
	localparam int PROD_W   = MS_W + CLK_W;
	localparam int SAT_SH   = 26;
	localparam int TICK_W   = SAT_SH + 1;
	localparam int QUOT_W   = 33;
	localparam int RECIP_SH = 40;
	localparam int RECIP_W  = 34;
	localparam int HALF_W   = RECIP_W / 2;
	localparam int PP_W     = QUOT_W + HALF_W;
	localparam int SUM_W    = QUOT_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'd124) / 64'd125);
	localparam logic [PROD_W-1:0] SAT_LIMIT = PROD_W'(MS_PER_S) << SAT_SH;

	typedef struct packed {
		logic [MS_W-1:0] max_ms;
		logic [MS_W-1:0] min_ms;
	} in_t;

	typedef struct packed {
		logic [1:0] prescale_index;
		logic [6:0] start_count;
		logic [6:0] window_value;
		logic       used_fallback;
	} out_t;

endpackage

### design/wwts_ticks.sv
// Milliseconds to clock ticks: multiply, then divide by 1000 through a reciprocal
module wwts_ticks import wwts_pkg::*; (
	input  logic              clk,
	input  logic [MS_W-1:0]   ms,
	input  logic [CLK_W-1:0]  clk_hz,
	output logic [TICK_W-1:0] ticks
);

	logic [PROD_W-1:0] prod_s2;
	logic              big_s3;
	logic [PP_W-1:0]   lo_s3;
	logic [PP_W-1:0]   hi_s3;
	logic [QUOT_W-1:0] quot;
	logic [SUM_W-1:0]  sum;
	logic [TICK_W-1:0] ticks_s4;

	assign quot = prod_s2[QUOT_W+2:3];
	assign sum  = SUM_W'(lo_s3) + (SUM_W'(hi_s3) << HALF_W);

	always_ff @(posedge clk) begin
		prod_s2  <= PROD_W'(ms) * PROD_W'(clk_hz);
		big_s3   <= prod_s2 >= SAT_LIMIT;
		lo_s3    <= PP_W'(quot) * PP_W'(RECIP[HALF_W-1:0]);
		hi_s3    <= PP_W'(quot) * PP_W'(RECIP[RECIP_W-1:HALF_W]);
		// saturate: beyond this every divisor gives a count above the counter range
		ticks_s4 <= big_s3 ? (TICK_W'(1) << SAT_SH)
			: {1'b0, sum[RECIP_SH+SAT_SH-1:RECIP_SH]};
	end

	assign ticks = ticks_s4;

endmodule

### design/wwts_select.sv
// Prescaler trials in parallel lanes and first-fit selection
module wwts_select import wwts_pkg::*; #(
	parameter int NUM_DIVIDERS = NUM_DIVIDERS_DEF
) (
	input  logic [TICK_W-1:0] tmo_ticks,
	input  logic [TICK_W-1:0] win_ticks,
	output out_t              res
);

	logic [NUM_DIVIDERS-1:0] ok;
	logic [6:0]              cnt [NUM_DIVIDERS];
	logic [6:0]              win [NUM_DIVIDERS];

	for (genvar k = 0; k < NUM_DIVIDERS; k++) begin : g_lane
		localparam int SH = BASE_SHIFT + k;
		logic [TICK_W:0] tsum;
		logic [TICK_W:0] wsum;
		logic [TICK_W:0] cf;
		logic [TICK_W:0] wf;
		logic [6:0]      cnt7;
		logic [6:0]      diff;
		logic [6:0]      winc;

		always_comb begin
			tsum = {1'b0, tmo_ticks} + ((TICK_W+1)'(1) << SH) - (TICK_W+1)'(1);
			wsum = {1'b0, win_ticks} + ((TICK_W+1)'(1) << SH) - (TICK_W+1)'(1);
			cf   = tsum >> SH;
			wf   = wsum >> SH;
			cnt7 = {1'b1, cf[5:0]};
			diff = cnt7 - wf[6:0];
			winc = (diff < COUNT_LOW) ? COUNT_LOW : diff;
			ok[k]  = (cf <= (TICK_W+1)'(COUNT_HIGH - COUNT_LOW))
				&& (wf < (TICK_W+1)'(cnt7)) && (cnt7 > winc);
			cnt[k] = cnt7;
			win[k] = winc;
		end
	end

	always_comb begin
		res.prescale_index = 2'(NUM_DIVIDERS - 1);
		res.start_count    = COUNT_HIGH;
		res.window_value   = COUNT_LOW;
		res.used_fallback  = 1'b1;
		// walk down so the lowest fitting index is left standing
		for (int k = NUM_DIVIDERS - 1; k >= 0; k--) begin
			if (ok[k]) begin
				res.prescale_index = 2'(k);
				res.start_count    = cnt[k];
				res.window_value   = win[k];
				res.used_fallback  = 1'b0;
			end
		end
	end

endmodule

### design/window_watchdog_timing_solver.sv
// Top level of the window watchdog timing solver
//
//  channel   | handshake            | word
//  ----------+----------------------+---------------------------------
//  request   | start, busy          | in_t: max_ms, min_ms
//  result    | done (strobe)        | out_t: prescale_index, start_count,
//            |                      |        window_value, used_fallback
//  cfg       | cfg_valid, cfg_ready | cfg_data: pclk_hz
//
// One word per cycle. Each request passes the input register, then the tick
// conversion: product, reciprocal partial products, their sum; then the
// prescaler lanes feed the result register.
// busy never rises and the receiver cannot stall, so nothing holds back.
// Reset clears the pipeline valid bits and loads pclk_hz with 108 MHz.
// cfg_ready is high only while no word is in flight.
`include "window_watchdog_timing_solver_defines.svh"

module window_watchdog_timing_solver import wwts_pkg::*; #(
	parameter int NUM_DIVIDERS = NUM_DIVIDERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_t         request,
	output logic        done,
	output out_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [CLK_W-1:0]  pclk_q;
	logic [CLK_W-1:0]  clk_hz;
	logic [4:0]        vld_q;
	in_t               req_s1;
	logic [TICK_W-1:0] tmo_ticks;
	logic [TICK_W-1:0] win_ticks;
	out_t              res;
	out_t              res_s5;

	assign busy      = 1'b0;
	assign cfg_ready = ~|vld_q;
	assign clk_hz    = (pclk_q == '0) ? DEFAULT_CLOCK_HZ : pclk_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclk_q <= DEFAULT_CLOCK_HZ;
			vld_q  <= '0;
		end else begin
			vld_q <= {vld_q[3:0], start & ~busy};
			if (cfg_valid && cfg_ready) begin
				pclk_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
		res_s5 <= res;
	end

	wwts_ticks u_tmo (
		.clk    (clk),
		.ms     (req_s1.max_ms),
		.clk_hz (clk_hz),
		.ticks  (tmo_ticks)
	);

	wwts_ticks u_win (
		.clk    (clk),
		.ms     (req_s1.min_ms),
		.clk_hz (clk_hz),
		.ticks  (win_ticks)
	);

	wwts_select #(
		.NUM_DIVIDERS (NUM_DIVIDERS)
	) u_select (
		.tmo_ticks (tmo_ticks),
		.win_ticks (win_ticks),
		.res       (res)
	);

	assign done   = vld_q[4];
	assign result = res_s5;

	`WWTS_ASSERT_IMP(a_fallback_fixed, clk, arst_n, done && result.used_fallback,
		result.start_count == COUNT_HIGH && result.window_value == COUNT_LOW,
		"fallback result not at fixed settings")
	`WWTS_ASSERT_IMP(a_window_below, clk, arst_n, done && !result.used_fallback,
		result.window_value < result.start_count && result.window_value >= COUNT_LOW,
		"window not below counter")
	`WWTS_ASSERT_NXT(a_cfg_blocked, clk, arst_n, start && !busy, !cfg_ready,
		"config open while a word is in flight")

endmodule
